/* hdl/wad_pkg.sv */
// ----------------------------------------------------------------------------
// wad_pkg: shared types and constants for the window average decimator
// Payload structs, controller commands and status, state encoding.
// ----------------------------------------------------------------------------
package wad_pkg;

	localparam int unsigned MAX_WINDOW = 255;
	localparam int unsigned SAMPLE_W   = 8;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned SUM_W      = 16;
	localparam int unsigned DIV_STEPS  = SUM_W;
	localparam int unsigned ITER_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                buffer_end;
	} wad_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic                is_last;
	} wad_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} wad_state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic load_out;
	} wad_cmd_t;

	typedef struct packed {
		logic closes;
		logic div_last;
		logic out_free;
	} wad_sts_t;

endpackage

/* hdl/window_average_decimator.sv */
// ----------------------------------------------------------------------------
// window_average_decimator: box filter with decimation
// Averages unsigned 8-bit samples over non-overlapping windows.
// ----------------------------------------------------------------------------
// A sample that does not close a window is taken without a stall. A sample that
// closes a window (count reaches window_length, or buffer_end is set) starts a
// one-bit-per-cycle restoring divide of the 16-bit window sum by its count:
// the block then goes through accept, 16 divide steps and the output load for
// that sample and stalls its input meanwhile. The mean waits in an output
// register, so the next window can start while it is held. window_length of
// zero acts as one; a new length applies from the next sample and must be
// written while the block is idle.
module window_average_decimator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wad_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  wad_pkg::wad_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output wad_pkg::wad_out_t            out_data
);
	import wad_pkg::*;

	wad_cmd_t cmd;
	wad_sts_t sts;

	wad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wad_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* hdl/wad_ctrl.sv */
// ----------------------------------------------------------------------------
// wad_ctrl: sequencing controller
// Accepts samples, runs the divider when a window closes, hands the mean on.
// ----------------------------------------------------------------------------
module wad_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wad_pkg::wad_sts_t sts,
	output wad_pkg::wad_cmd_t cmd
);
	import wad_pkg::*;

	wad_state_t state_q;
	wad_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.closes) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd.accept   = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = sts.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

/* hdl/wad_datapath.sv */
// ----------------------------------------------------------------------------
// wad_datapath: window accumulator, restoring divider and output register
// One quotient bit per step; the output register holds the mean until taken.
// ----------------------------------------------------------------------------
module wad_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wad_pkg::COUNT_W-1:0]  cfg_wdata,
	input  wad_pkg::wad_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output wad_pkg::wad_out_t            out_data,
	input  wad_pkg::wad_cmd_t            cmd,
	output wad_pkg::wad_sts_t            sts
);
	import wad_pkg::*;

	logic [COUNT_W-1:0] len_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   quot_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] div_q;
	logic               zero_q;
	logic               last_q;
	logic [ITER_W-1:0]  iter_q;
	logic               out_valid_q;
	wad_out_t           out_data_q;

	logic [COUNT_W-1:0] eff_len;
	logic [SUM_W-1:0]   sum_nxt;
	logic [COUNT_W-1:0] count_nxt;
	logic [COUNT_W:0]   trial;
	logic               ge;

	always_comb begin
		eff_len = len_q;
		if (len_q == '0) begin
			eff_len = COUNT_W'(1);
		end
		if (32'(len_q) > MAX_WINDOW) begin
			eff_len = COUNT_W'(MAX_WINDOW);
		end
	end

	assign sum_nxt   = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, in_data.sample};
	assign count_nxt = count_q + COUNT_W'(1);

	assign sts.closes   = (count_nxt == '0) || (count_nxt >= eff_len) || in_data.buffer_end;
	assign sts.div_last = (iter_q == ITER_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= COUNT_W'(1);
			sum_q   <= '0;
			count_q <= '0;
			iter_q  <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				iter_q <= '0;
				if (sts.closes) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_nxt;
					count_q <= count_nxt;
				end
			end else if (cmd.step) begin
				iter_q <= iter_q + ITER_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.closes) begin
			quot_q <= sum_nxt;
			rem_q  <= '0;
			div_q  <= count_nxt;
			zero_q <= (count_nxt == '0);
			last_q <= in_data.buffer_end;
		end else if (cmd.step) begin
			quot_q <= {quot_q[SUM_W-2:0], ge};
			rem_q  <= ge ? COUNT_W'(trial - {1'b0, div_q}) : trial[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q.mean    <= zero_q ? '0 : quot_q[SAMPLE_W-1:0];
			out_data_q.is_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* bench/window_average_decimator_test.sv */
// ----------------------------------------------------------------------------
// window_average_decimator_test: self-checking bench for the window averager
// Drives samples through the valid/stall channels with random idle bursts on
// both sides. A scoreboard tracks the open window and the configured length,
// predicts each mean, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module window_average_decimator_test;
	import wad_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int NUM_PHASES    = 12;

	class mean_scoreboard;
		logic [COUNT_W-1:0] len_reg;
		logic [SUM_W-1:0]   acc_sum;
		logic [COUNT_W-1:0] acc_count;
		wad_out_t           pending_means[$];
		int                 errors;

		function new();
			len_reg   = COUNT_W'(1);
			acc_sum   = '0;
			acc_count = '0;
			errors    = 0;
		endfunction

		function void set_length(logic [COUNT_W-1:0] v);
			len_reg = v;
		endfunction

		function void note_sample(wad_in_t t);
			int unsigned eff;
			wad_out_t    r;
			eff = (len_reg == 0) ? 1 : len_reg;
			if (eff > MAX_WINDOW)
				eff = MAX_WINDOW;
			acc_sum   = acc_sum + t.sample;
			acc_count = acc_count + 1'b1;
			if (acc_count != 0 && acc_count < eff && !t.buffer_end)
				return;
			r.mean    = (acc_count != 0) ? SAMPLE_W'(acc_sum / acc_count) : '0;
			r.is_last = t.buffer_end;
			pending_means = {pending_means, r};
			acc_sum   = '0;
			acc_count = '0;
		endfunction

		function void check_result(wad_out_t got);
			wad_out_t want;
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual mean=%0d is_last=%0d",
					$time, got.mean, got.is_last);
				errors++;
				return;
			end
			want = pending_means.pop_front();
			if (got.mean !== want.mean) begin
				$display("%0t: mean mismatch, expected %0d actual %0d",
					$time, want.mean, got.mean);
				errors++;
			end
			if (got.is_last !== want.is_last) begin
				$display("%0t: is_last mismatch, expected %0d actual %0d",
					$time, want.is_last, got.is_last);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	wad_in_t            in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	wad_out_t           out_data;

	mean_scoreboard sb = new();
	int             idle_odds = 0;
	int             stall_left = 0;
	int             cycles = 0;

	int phase_len[NUM_PHASES]   = '{255, 1, 0, 2, 3, 5, 16, 128, -1, -1, 7, 4};
	int phase_items[NUM_PHASES] = '{300, 60, 40, 80, 80, 80, 80, 60, 80, 80, 60, 40};
	int phase_be[NUM_PHASES]    = '{0, 8, 8, 10, 10, 12, 20, 40, 16, 16, 10, 6};
	int phase_idle[NUM_PHASES]  = '{30, 25, 0, 40, 20, 35, 0, 25, 30, 45, 20, 0};

	window_average_decimator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("window_average_decimator verification failed");
			$finish;
		end
	end

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_odds > 0 && $urandom_range(99) < idle_odds) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic be);
		int gap;
		if (idle_odds > 0 && $urandom_range(99) < idle_odds) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= '{sample: s, buffer_end: be};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [COUNT_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_length(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int len;
		int pick;
		logic [SAMPLE_W-1:0] s;
		logic be;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length passes samples through
		idle_odds = 30;
		send_sample(8'd0, 1'b0);
		send_sample(8'd255, 1'b1);
		send_sample(8'd170, 1'b0);

		// zero length acts as one
		wait_idle();
		write_length(8'd0);
		send_sample(8'd85, 1'b1);
		send_sample(8'd1, 1'b0);

		// full window, partial window, buffer end on a fresh window
		wait_idle();
		write_length(8'd4);
		send_sample(8'd255, 1'b0);
		send_sample(8'd255, 1'b0);
		send_sample(8'd255, 1'b0);
		send_sample(8'd254, 1'b0);
		send_sample(8'd10, 1'b0);
		send_sample(8'd20, 1'b0);
		send_sample(8'd31, 1'b1);
		send_sample(8'd77, 1'b1);
		send_sample(8'd3, 1'b0);
		send_sample(8'd4, 1'b0);

		// shorter length with the open window already at that length
		wait_idle();
		write_length(8'd2);
		send_sample(8'd8, 1'b0);
		send_sample(8'd100, 1'b0);
		send_sample(8'd0, 1'b0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			len = (phase_len[p] < 0) ? $urandom_range(1, 255) : phase_len[p];
			write_length(len[COUNT_W-1:0]);
			idle_odds = phase_idle[p];
			for (int i = 0; i < phase_items[p]; i++) begin
				pick = $urandom_range(7);
				if (pick == 0)
					s = 8'd0;
				else if (pick == 1)
					s = 8'd255;
				else
					s = SAMPLE_W'($urandom_range(255));
				be = (phase_be[p] == 0) ? 1'b0 : ($urandom_range(phase_be[p] - 1) == 0);
				send_sample(s, be);
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending_means.size() == 0) begin
			$display("window_average_decimator verification clean");
		end else begin
			$display("window_average_decimator verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/wad_pkg.sv
hdl/wad_ctrl.sv
hdl/wad_datapath.sv
hdl/window_average_decimator.sv
bench/window_average_decimator_test.sv
